// ===== hdl/two_ended_heap_allocator_macros.svh =====
// assertion macros used by the allocator module
`ifndef TWO_ENDED_HEAP_ALLOCATOR_MACROS_SVH
`define TWO_ENDED_HEAP_ALLOCATOR_MACROS_SVH
// property must hold after reset
`define TEHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define TEHA_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define TEHA_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/teha_pkg.sv =====
`timescale 1ns / 1ps
package teha_pkg;
  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_RESIZE  = 3'd2,
    CMD_INSPECT = 3'd3,
    CMD_TRIM    = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_GROUP = 2'd1;
  localparam logic [1:0] REG_BASE  = 2'd2;
  localparam logic [1:0] REG_SIZE  = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] request_size;
    logic [4:0]  align_log2;
    logic        from_top;
    logic [31:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [7:0]  block_group;
    logic        block_top;
    logic [31:0] largest_free;
    logic [31:0] total_free;
  } out_item_t;
endpackage

// ===== hdl/two_ended_heap_allocator.sv =====
`timescale 1ns / 1ps
// sequencing: per command, one pass over each table to search, one more over each table to
//   shift entries on insert or remove, and one pass over the free table for the largest and
//   total sums; one table port each
// throughput: one command at a time, the next is taken once the result transaction is taken
// reset: synchronous active low; empty heap, zero configuration registers, no clearing pass
module two_ended_heap_allocator #(
  parameter int FREE_ENTRIES = 64,
  parameter int USED_ENTRIES = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  teha_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output teha_pkg::out_item_t       out_data,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [3:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import teha_pkg::*;
  `include "two_ended_heap_allocator_macros.svh"

  localparam int FAW = $clog2(FREE_ENTRIES);
  localparam int UAW = $clog2(USED_ENTRIES);
  localparam int FCW = $clog2(FREE_ENTRIES + 1);
  localparam int UCW = $clog2(USED_ENTRIES + 1);
  localparam logic [FCW-1:0] FREE_MAX = FCW'(FREE_ENTRIES);
  localparam logic [UCW-1:0] USED_MAX = UCW'(USED_ENTRIES);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_DEC    = 16'h0002,
    S_USCAN  = 16'h0004,
    S_FSCAN  = 16'h0008,
    S_ACT    = 16'h0010,
    S_FSHR   = 16'h0020,
    S_FSHL   = 16'h0040,
    S_USHR   = 16'h0080,
    S_USHL   = 16'h0100,
    S_FPUT   = 16'h0200,
    S_SUM    = 16'h0400,
    S_DONE   = 16'h0800,
    S_UPUT   = 16'h1000,
    S_UPOS   = 16'h2000,
    S_FPOS   = 16'h4000,
    S_AFTER  = 16'h8000
  } state_t;

  // memories: free table {start,length}, used table {start,length,tag}
  logic           fm_we;
  logic [FAW-1:0] fm_wa, fm_ra;
  logic [63:0]    fm_wd, fm_rd;
  logic           um_we;
  logic [UAW-1:0] um_wa, um_ra;
  logic [72:0]    um_wd, um_rd;

  teha_ram #(.WIDTH(64), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk(clk), .we(fm_we), .waddr(fm_wa), .wdata(fm_wd), .raddr(fm_ra), .rdata(fm_rd));
  teha_ram #(.WIDTH(73), .DEPTH(USED_ENTRIES)) u_used_ram (
    .clk(clk), .we(um_we), .waddr(um_wa), .wdata(um_wd), .raddr(um_ra), .rdata(um_rd));

  // configuration registers
  logic        mode_r;
  logic [7:0]  group_r;
  logic [31:0] base_r, hsize_r, limit_r;
  logic [FCW-1:0] fcnt_r;
  logic [UCW-1:0] ucnt_r;
  logic           cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MODE:  cfg_prdata = {31'd0, mode_r};
      REG_GROUP: cfg_prdata = {24'd0, group_r};
      REG_BASE:  cfg_prdata = base_r;
      default:   cfg_prdata = hsize_r;
    endcase
  end

  state_t state_r;
  in_item_t  cmd_r;
  out_item_t res_r;
  logic           ovalid_r;
  logic [31:0]    off_r, sz_r;
  // scan index, address issued last cycle
  logic [12:0]    k_r;
  logic           rdv_r;
  logic [12:0]    rk_r;
  // search results
  logic           uf_r;
  logic [UAW-1:0] ui_r;
  logic [31:0]    us_r, ul_r;
  logic [8:0]     ut_r;
  logic           pv_r, nx_r, pk_r;
  logic [FAW-1:0] pvi_r, nxi_r, pki_r;
  logic [31:0]    pvl_r, nxs_r, nxl_r, pks_r, pkl_r;
  // pending edit plan
  logic [FAW-1:0] fpos_r;
  logic [UAW-1:0] upos_r;
  logic [63:0]    fput_r;
  logic [72:0]    uput_r;
  logic           fins_r, uins_r, frem_r, urem_r;
  logic [31:0]    lg_r, tot_r;
  logic [31:0]    val_r;
  logic [1:0]     st_r;
  logic [31:0]    shbuf_r;

  logic [32:0] pad;
  logic [31:0] amask;
  always_comb begin
    amask = (32'd1 << cmd_r.align_log2) - 32'd1;
    pad = ({1'b0, cmd_r.request_size} + {1'b0, amask}) & ~{1'b0, amask};
  end

  // memory port drive is registered by plan; compute per state
  logic [31:0] f_s, f_l, fe;
  assign f_s = fm_rd[63:32];
  assign f_l = fm_rd[31:0];
  assign fe  = f_s + f_l;

  logic [FCW-1:0] k_f;
  logic [UCW-1:0] k_u;
  assign k_f = FCW'(k_r);
  assign k_u = UCW'(k_r);

  always_comb begin
    fm_we = 1'b0; fm_wa = '0; fm_wd = fput_r; fm_ra = k_r[FAW-1:0];
    um_we = 1'b0; um_wa = '0; um_wd = uput_r; um_ra = k_r[UAW-1:0];
    unique case (state_r)
      S_FSCAN: begin
        if (cmd_r.from_top && cmd_r.command == CMD_ALLOC)
          fm_ra = FAW'(fcnt_r - FCW'(1) - k_f);
      end
      S_FSHR: begin
        // read entry k-1, write the entry read last cycle one slot up
        fm_ra = FAW'(k_r - 13'd1);
        fm_we = rdv_r; fm_wa = FAW'(rk_r + 13'd1); fm_wd = fm_rd;
      end
      S_FSHL: begin
        fm_ra = FAW'(k_r);
        fm_we = rdv_r; fm_wa = FAW'(rk_r - 13'd1); fm_wd = fm_rd;
      end
      S_USHR: begin
        um_ra = UAW'(k_r - 13'd1);
        um_we = rdv_r; um_wa = UAW'(rk_r + 13'd1); um_wd = um_rd;
      end
      S_USHL: begin
        um_ra = UAW'(k_r);
        um_we = rdv_r; um_wa = UAW'(rk_r - 13'd1); um_wd = um_rd;
      end
      S_FPUT: begin
        fm_we = 1'b1; fm_wa = fpos_r;
      end
      S_UPUT: begin
        um_we = 1'b1; um_wa = upos_r;
      end
      default: ;
    endcase
    // heap size write loads the whole heap as free entry 0
    if (cfg_wr && cfg_paddr[3:2] == REG_SIZE) begin
      fm_we = 1'b1; fm_wa = '0; fm_wd = {32'd0, cfg_pwdata};
    end
  end

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ovalid_r <= 1'b0;
      mode_r <= 1'b0; group_r <= '0; base_r <= '0; hsize_r <= '0; limit_r <= '0;
      fcnt_r <= '0; ucnt_r <= '0; fput_r <= '0; fpos_r <= '0;
    end else begin
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          REG_MODE:  mode_r <= cfg_pwdata[0];
          REG_GROUP: group_r <= cfg_pwdata[7:0];
          REG_BASE:  base_r <= cfg_pwdata;
          default: begin
            hsize_r <= cfg_pwdata; limit_r <= cfg_pwdata;
            ucnt_r <= '0;
            fcnt_r <= (cfg_pwdata != 0) ? FCW'(1) : '0;
          end
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r <= in_data;
            off_r <= in_data.block_address - base_r;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          uf_r <= 1'b0; pv_r <= 1'b0; nx_r <= 1'b0; pk_r <= 1'b0;
          fins_r <= 1'b0; uins_r <= 1'b0; frem_r <= 1'b0; urem_r <= 1'b0;
          val_r <= '0; st_r <= ST_NONE; ut_r <= '0;
          k_r <= '0; rdv_r <= 1'b0; sz_r <= pad[31:0];
          if (cmd_r.command == CMD_FREE || cmd_r.command == CMD_RESIZE
              || cmd_r.command == CMD_INSPECT) begin
            state_r <= S_USCAN;
          end else if (cmd_r.command == CMD_ALLOC) begin
            if (cmd_r.request_size == 0 || pad[32]) state_r <= S_AFTER;
            else if (ucnt_r >= USED_MAX) begin
              st_r <= ST_FULL; state_r <= S_AFTER;
            end else state_r <= S_FSCAN;
          end else if (cmd_r.command == CMD_TRIM) begin
            st_r <= ST_OK;
            if (fcnt_r != 0) begin
              k_r <= 13'(fcnt_r - FCW'(1)); state_r <= S_FSCAN;
            end else begin
              val_r <= limit_r; state_r <= S_AFTER;
            end
          end else state_r <= S_AFTER;
        end
        // look up the used block by start offset
        S_USCAN: begin
          rdv_r <= k_u < ucnt_r;
          rk_r <= k_r;
          if (k_u < ucnt_r) k_r <= k_r + 13'd1;
          if (rdv_r && !uf_r && um_rd[72:41] == off_r) begin
            uf_r <= 1'b1; ui_r <= UAW'(rk_r);
            us_r <= um_rd[72:41]; ul_r <= um_rd[40:9]; ut_r <= um_rd[8:0];
          end
          if (!rdv_r && k_r != 0 || ucnt_r == 0) begin
            k_r <= '0; rdv_r <= 1'b0; state_r <= S_FSCAN;
          end
        end
        // scan free table: neighbors, fit search, trim tail
        S_FSCAN: begin
          if (cmd_r.command == CMD_TRIM) begin
            if (!rdv_r) rdv_r <= 1'b1;
            else begin
              if (fe == limit_r) begin
                limit_r <= limit_r - f_l; fcnt_r <= fcnt_r - FCW'(1);
                val_r <= limit_r - f_l;
              end else val_r <= limit_r;
              state_r <= S_AFTER;
            end
          end else if (cmd_r.command != CMD_ALLOC && !uf_r) begin
            state_r <= S_AFTER;
          end else begin
            rdv_r <= k_f < fcnt_r;
            rk_r <= (cmd_r.command == CMD_ALLOC && cmd_r.from_top) ?
                    13'(fcnt_r - FCW'(1) - k_f) : k_r;
            if (k_f < fcnt_r) k_r <= k_r + 13'd1;
            if (rdv_r) begin
              if (cmd_r.command == CMD_ALLOC) begin
                if (f_l >= sz_r && (!pk_r || (mode_r && f_l < pkl_r))) begin
                  if (!(pk_r && !mode_r)) begin
                    pk_r <= 1'b1; pki_r <= FAW'(rk_r); pks_r <= f_s; pkl_r <= f_l;
                  end
                end
              end else begin
                if (!pv_r && fe == us_r) begin
                  pv_r <= 1'b1; pvi_r <= FAW'(rk_r); pvl_r <= f_l;
                end
                if (!nx_r && f_s == us_r + ul_r) begin
                  nx_r <= 1'b1; nxi_r <= FAW'(rk_r); nxs_r <= f_s; nxl_r <= f_l;
                end
              end
            end
            if ((!rdv_r && k_r != 0) || fcnt_r == 0) state_r <= S_ACT;
          end
        end
        // decide the edit
        S_ACT: begin
          state_r <= S_AFTER;
          if (cmd_r.command == CMD_ALLOC) begin
            if (pk_r) begin
              st_r <= ST_OK;
              shbuf_r <= cmd_r.from_top ? pks_r + pkl_r - sz_r : pks_r;
              val_r <= base_r + (cmd_r.from_top ? pks_r + pkl_r - sz_r : pks_r);
              uput_r <= {(cmd_r.from_top ? pks_r + pkl_r - sz_r : pks_r), sz_r,
                         cmd_r.from_top, group_r};
              fpos_r <= pki_r;
              fput_r <= {(cmd_r.from_top ? pks_r : pks_r + sz_r), pkl_r - sz_r};
              frem_r <= pkl_r == sz_r;
              uins_r <= 1'b1;
              k_r <= '0; rdv_r <= 1'b0;
              state_r <= (pkl_r == sz_r) ? S_FPOS : S_FPUT;
            end
          end else if (cmd_r.command == CMD_INSPECT) begin
            st_r <= ST_OK; val_r <= ul_r;
          end else if (cmd_r.command == CMD_FREE) begin
            st_r <= ST_OK; urem_r <= 1'b1; upos_r <= ui_r;
            if (pv_r && nx_r) begin
              fpos_r <= pvi_r; fput_r <= {us_r - pvl_r, pvl_r + ul_r + nxl_r};
              frem_r <= 1'b1; state_r <= S_FPUT;
            end else if (nx_r) begin
              fpos_r <= nxi_r; fput_r <= {nxs_r - ul_r, nxl_r + ul_r}; state_r <= S_FPUT;
            end else if (pv_r) begin
              fpos_r <= pvi_r; fput_r <= {us_r - pvl_r, pvl_r + ul_r}; state_r <= S_FPUT;
            end else if (fcnt_r >= FREE_MAX) begin
              st_r <= ST_FULL; urem_r <= 1'b0;
            end else begin
              fput_r <= {us_r, ul_r}; fins_r <= 1'b1; k_r <= '0; rdv_r <= 1'b0;
              state_r <= S_FPOS;
            end
          end else begin
            // resize
            if (cmd_r.request_size == 0) ;
            else if (cmd_r.request_size < ul_r) begin
              st_r <= ST_OK; val_r <= cmd_r.request_size;
              uput_r <= {us_r, cmd_r.request_size, ut_r}; upos_r <= ui_r;
              if (nx_r) begin
                fpos_r <= nxi_r;
                fput_r <= {nxs_r - (ul_r - cmd_r.request_size),
                           nxl_r + (ul_r - cmd_r.request_size)};
                state_r <= S_FPUT;
              end else if (fcnt_r >= FREE_MAX) begin
                st_r <= ST_FULL; val_r <= '0;
              end else begin
                fput_r <= {us_r + cmd_r.request_size, ul_r - cmd_r.request_size};
                fins_r <= 1'b1; k_r <= '0; rdv_r <= 1'b0; state_r <= S_FPOS;
              end
            end else if (cmd_r.request_size > ul_r) begin
              if (nx_r && cmd_r.request_size - ul_r <= nxl_r) begin
                st_r <= ST_OK; val_r <= cmd_r.request_size;
                uput_r <= {us_r, cmd_r.request_size, ut_r}; upos_r <= ui_r;
                fpos_r <= nxi_r;
                fput_r <= {nxs_r + (cmd_r.request_size - ul_r),
                           nxl_r - (cmd_r.request_size - ul_r)};
                frem_r <= cmd_r.request_size - ul_r == nxl_r;
                state_r <= (cmd_r.request_size - ul_r == nxl_r) ? S_FPOS : S_FPUT;
                if (cmd_r.request_size - ul_r == nxl_r) begin
                  fpos_r <= nxi_r; frem_r <= 1'b1;
                end
              end
            end else begin
              st_r <= ST_OK; val_r <= ul_r;
              uput_r <= {us_r, ul_r, ut_r}; upos_r <= ui_r;
            end
          end
        end
        // set up a free table shift
        S_FPOS: begin
          if (frem_r) begin
            // remove fpos: copy fpos+1.. down
            k_r <= 13'(fpos_r) + 13'd1; rdv_r <= 1'b0; state_r <= S_FSHL;
          end else begin
            // find insert position (first start > new start)
            rdv_r <= k_f < fcnt_r; rk_r <= k_r;
            if (k_f < fcnt_r) k_r <= k_r + 13'd1;
            if (rdv_r && f_s > fput_r[63:32]) begin
              fpos_r <= FAW'(rk_r); k_r <= 13'(fcnt_r); rdv_r <= 1'b0;
              state_r <= S_FSHR;
            end else if ((!rdv_r && k_r != 0) || fcnt_r == 0) begin
              fpos_r <= FAW'(fcnt_r); k_r <= 13'(fcnt_r); rdv_r <= 1'b0;
              state_r <= S_FSHR;
            end
          end
        end
        S_FSHR: begin
          // reads k-1 down to fpos, writes one above
          rdv_r <= k_r > 13'(fpos_r);
          rk_r <= k_r - 13'd1;
          if (k_r > 13'(fpos_r)) k_r <= k_r - 13'd1;
          if (!(k_r > 13'(fpos_r)) && !rdv_r) begin
            state_r <= S_FPUT;
          end
        end
        S_FSHL: begin
          rdv_r <= k_f < fcnt_r; rk_r <= k_r;
          if (k_f < fcnt_r) k_r <= k_r + 13'd1;
          if (!(k_f < fcnt_r) && !rdv_r) begin
            fcnt_r <= fcnt_r - FCW'(1); frem_r <= 1'b0;
            state_r <= S_AFTER;
          end
        end
        S_FPUT: begin
          if (fins_r) fcnt_r <= fcnt_r + FCW'(1);
          fins_r <= 1'b0;
          if (frem_r) begin
            // double merge: drop the upper neighbor
            fpos_r <= nxi_r;
            state_r <= S_FPOS;
          end else state_r <= S_AFTER;
        end
        // used table edits
        S_AFTER: begin
          k_r <= '0; rdv_r <= 1'b0;
          if (uins_r) begin
            upos_r <= '0; state_r <= S_UPOS;
          end else if (urem_r) begin
            k_r <= 13'(upos_r) + 13'd1; state_r <= S_USHL;
          end else if (st_r == ST_OK && cmd_r.command == CMD_RESIZE) begin
            state_r <= S_UPUT;
          end else begin
            lg_r <= '0; tot_r <= '0; state_r <= S_SUM;
          end
        end
        S_UPOS: begin
          rdv_r <= k_u < ucnt_r; rk_r <= k_r;
          if (k_u < ucnt_r) k_r <= k_r + 13'd1;
          if (rdv_r && um_rd[72:41] > shbuf_r) begin
            upos_r <= UAW'(rk_r); k_r <= 13'(ucnt_r); rdv_r <= 1'b0; state_r <= S_USHR;
          end else if ((!rdv_r && k_r != 0) || ucnt_r == 0) begin
            upos_r <= UAW'(ucnt_r); k_r <= 13'(ucnt_r); rdv_r <= 1'b0; state_r <= S_USHR;
          end
        end
        S_USHR: begin
          rdv_r <= k_r > 13'(upos_r); rk_r <= k_r - 13'd1;
          if (k_r > 13'(upos_r)) k_r <= k_r - 13'd1;
          if (!(k_r > 13'(upos_r)) && !rdv_r) begin
            ucnt_r <= ucnt_r + UCW'(1); uins_r <= 1'b0; state_r <= S_UPUT;
          end
        end
        S_USHL: begin
          rdv_r <= k_u < ucnt_r; rk_r <= k_r;
          if (k_u < ucnt_r) k_r <= k_r + 13'd1;
          if (!(k_u < ucnt_r) && !rdv_r) begin
            ucnt_r <= ucnt_r - UCW'(1); urem_r <= 1'b0;
            lg_r <= '0; tot_r <= '0; k_r <= '0; state_r <= S_SUM;
          end
        end
        S_UPUT: begin
          lg_r <= '0; tot_r <= '0; k_r <= '0; rdv_r <= 1'b0; state_r <= S_SUM;
        end
        // largest and total over the free table
        S_SUM: begin
          if (cmd_r.command == CMD_ALLOC && pk_r && uins_r) begin
            state_r <= S_AFTER;
          end else begin
            rdv_r <= k_f < fcnt_r;
            if (k_f < fcnt_r) k_r <= k_r + 13'd1;
            if (rdv_r) begin
              tot_r <= tot_r + f_l;
              if (f_l > lg_r) lg_r <= f_l;
            end
            if ((!rdv_r && k_r != 0) || fcnt_r == 0) state_r <= S_DONE;
            if (k_r == 0 && !rdv_r) begin
              lg_r <= '0; tot_r <= '0;
            end
          end
        end
        S_DONE: begin
          res_r.value <= val_r;
          res_r.status <= st_r;
          res_r.block_group <= (st_r == ST_OK && cmd_r.command == CMD_INSPECT) ?
                               ut_r[7:0] : 8'd0;
          res_r.block_top <= (st_r == ST_OK && cmd_r.command == CMD_INSPECT) ?
                             ut_r[8] : 1'b0;
          res_r.largest_free <= lg_r;
          res_r.total_free <= tot_r;
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `TEHA_IMPLY(a_cnt_free, 1'b1, fcnt_r <= FREE_MAX, "free count overflow")
  `TEHA_IMPLY(a_cnt_used, 1'b1, ucnt_r <= USED_MAX, "used count overflow")
  `TEHA_NEXT(a_done_valid, state_r == S_DONE, ovalid_r, "result not loaded")
  `TEHA_IMPLY(a_ready_idle, in_ready, !ovalid_r, "accept while result pending")
endmodule

// ===== hdl/teha_ram.sv =====
`timescale 1ns / 1ps
module teha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
